// File: design/plsbd_pkg.sv
// plsbd_pkg: shared types, constants and codes for the parallel LED strip bit-slice driver
// used by plsbd_store, plsbd_ctrl and parallel_led_strip_bitslice_driver_unit; no dependencies
`default_nettype none

package plsbd_pkg;

  localparam int LANES_DEF         = 16;
  localparam int LEDS_PER_LANE_DEF = 24;

  // one LED: green, red, blue, sent msb first
  localparam int COLOR_W  = 24;
  localparam int BYTE_W   = 8;
  localparam int BIT_W    = 5;
  localparam int OP_W     = 2;
  localparam int LANE_W   = 4;
  localparam int LED_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(COLOR_W - 1);

  typedef enum logic [OP_W-1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_START     = 2'd1,
    OP_TICK      = 2'd2,
    OP_NOP       = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD_TICKS = 2'd0,
    CFG_DATA_TICK    = 2'd1,
    CFG_LOW_TICK     = 2'd2,
    CFG_DEAD_PERIODS = 2'd3
  } cfg_idx_e;

  localparam logic [BYTE_W-1:0] PERIOD_TICKS_RST = 8'd30;
  localparam logic [BYTE_W-1:0] DATA_TICK_RST    = 8'd10;
  localparam logic [BYTE_W-1:0] LOW_TICK_RST     = 8'd19;
  localparam logic [BYTE_W-1:0] DEAD_PERIODS_RST = 8'd19;

  typedef struct packed {
    logic [BYTE_W-1:0] period_ticks;
    logic [BYTE_W-1:0] data_tick;
    logic [BYTE_W-1:0] low_tick;
    logic [BYTE_W-1:0] dead_periods;
  } cfg_t;

  // count loaded at start so that the first tick wraps
  function automatic logic [BYTE_W-1:0] preload(input logic [BYTE_W-1:0] period);
    logic [BYTE_W-1:0] res;
    res = (period == '0) ? '0 : period - BYTE_W'(1);
    return res;
  endfunction

endpackage

`default_nettype wire

// File: design/plsbd_store.sv
// plsbd_store: bit-sliced frame store, one row per LED position holding all lanes
// with a clearing pass after reset and a registered row read with write bypass; uses plsbd_pkg
`default_nettype none

module plsbd_store #(
  parameter int LANES = plsbd_pkg::LANES_DEF,
  parameter int ROWS  = plsbd_pkg::LEDS_PER_LANE_DEF,
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int LANE_AW = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       wr_en_i,
  input  wire logic [ROW_AW-1:0]                          wr_row_i,
  input  wire logic [LANE_AW-1:0]                         wr_lane_i,
  input  wire logic [plsbd_pkg::COLOR_W-1:0]              wr_data_i,
  input  wire logic [ROW_AW-1:0]                          rd_row_i,
  output logic      [LANES-1:0][plsbd_pkg::COLOR_W-1:0]   rd_data_o,
  output logic                                            clr_busy_o
);

  logic [LANES-1:0][plsbd_pkg::COLOR_W-1:0] mem_q [ROWS];
  logic [LANES-1:0][plsbd_pkg::COLOR_W-1:0] rd_q;
  logic [ROW_AW-1:0] clr_row_q, clr_row_d;
  logic              clr_busy_q, clr_busy_d;

  always_comb begin
    clr_row_d  = clr_row_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      if (clr_row_q == ROW_AW'(ROWS - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_row_d = clr_row_q + ROW_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_row_q  <= clr_row_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_row_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_row_i][wr_lane_i] <= wr_data_i;
    end
  end

  // read data follows a write to the same row in the same cycle
  always_ff @(posedge clk_i) begin : rd_port
    logic [LANES-1:0][plsbd_pkg::COLOR_W-1:0] rd_d;
    rd_d = mem_q[rd_row_i];
    if (clr_busy_q) begin
      if (clr_row_q == rd_row_i) begin
        rd_d = '0;
      end
    end else if (wr_en_i && (wr_row_i == rd_row_i)) begin
      rd_d[wr_lane_i] = wr_data_i;
    end
    rd_q <= rd_d;
  end

  assign rd_data_o  = rd_q;
  assign clr_busy_o = clr_busy_q;

endmodule

`default_nettype wire

// File: design/plsbd_ctrl.sv
// plsbd_ctrl: bit timing sequencer, word position, dead time and pin levels
// reads rows from plsbd_store and issues its pixel writes; uses plsbd_pkg
`default_nettype none

module plsbd_ctrl #(
  parameter int LANES = plsbd_pkg::LANES_DEF,
  parameter int ROWS  = plsbd_pkg::LEDS_PER_LANE_DEF,
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int LANE_AW = (LANES > 1) ? $clog2(LANES) : 1
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       step_i,
  input  wire plsbd_pkg::op_e                             op_i,
  input  wire logic [plsbd_pkg::LANE_W-1:0]               lane_i,
  input  wire logic [plsbd_pkg::LED_W-1:0]                led_i,
  input  wire logic [plsbd_pkg::COLOR_W-1:0]              color_i,
  input  wire plsbd_pkg::cfg_t                            cfg_i,
  output logic                                            wr_en_o,
  output logic      [ROW_AW-1:0]                          wr_row_o,
  output logic      [LANE_AW-1:0]                         wr_lane_o,
  output logic      [plsbd_pkg::COLOR_W-1:0]              wr_data_o,
  output logic      [ROW_AW-1:0]                          rd_row_o,
  input  wire logic [LANES-1:0][plsbd_pkg::COLOR_W-1:0]   rd_data_i,
  output logic      [LANES-1:0]                           pins_o,
  output logic                                            busy_o,
  output logic                                            done_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_DEAD = 2'd2
  } phase_e;

  phase_e                              phase_q, phase_d;
  logic [plsbd_pkg::BYTE_W-1:0]        tick_q, tick_d;
  logic [plsbd_pkg::BYTE_W-1:0]        dead_q, dead_d;
  logic [plsbd_pkg::BIT_W-1:0]         bit_q, bit_d;
  logic [ROW_AW-1:0]                   row_q, row_d;
  logic [LANES-1:0]                    pin_q, pin_d;
  logic                                done_q, done_d;

  logic [plsbd_pkg::BYTE_W:0]          tick_inc;
  logic [plsbd_pkg::BYTE_W-1:0]        tick_nxt;
  logic                                wrap;
  logic [plsbd_pkg::BIT_W-1:0]         bit_sel;
  logic [LANES-1:0]                    word;

  // current frame word: one bit of every lane at this LED
  always_comb begin
    bit_sel = plsbd_pkg::LAST_BIT - bit_q;
    for (int ln = 0; ln < LANES; ln++) begin
      word[ln] = rd_data_i[ln][bit_sel];
    end
  end

  assign tick_inc = {1'b0, tick_q} + (plsbd_pkg::BYTE_W + 1)'(1);
  assign wrap     = (tick_inc >= {1'b0, cfg_i.period_ticks});
  assign tick_nxt = wrap ? '0 : tick_inc[plsbd_pkg::BYTE_W-1:0];

  assign wr_en_o   = step_i && (op_i == plsbd_pkg::OP_SET_PIXEL)
                     && (32'(lane_i) < LANES) && (32'(led_i) < ROWS);
  assign wr_row_o  = ROW_AW'(led_i);
  assign wr_lane_o = LANE_AW'(lane_i);
  assign wr_data_o = color_i;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    dead_d  = dead_q;
    bit_d   = bit_q;
    row_d   = row_q;
    pin_d   = pin_q;
    done_d  = done_q;
    if (step_i) begin
      case (op_i)
        plsbd_pkg::OP_START: begin
          done_d  = 1'b0;
          phase_d = PH_SEND;
          bit_d   = '0;
          row_d   = '0;
          dead_d  = '0;
          tick_d  = plsbd_pkg::preload(cfg_i.period_ticks);
        end
        plsbd_pkg::OP_TICK: begin
          if (phase_q != PH_IDLE) begin
            tick_d = tick_nxt;
          end
          if (phase_q == PH_SEND) begin
            // when events coincide, the low level overrides the data bit, which overrides the wrap high
            if (wrap) begin
              pin_d = '1;
            end
            if (tick_nxt == cfg_i.data_tick) begin
              pin_d = word;
            end
            if (tick_nxt == cfg_i.low_tick) begin
              pin_d = '0;
              if (bit_q == plsbd_pkg::LAST_BIT) begin
                bit_d = '0;
                if (row_q == ROW_AW'(ROWS - 1)) begin
                  row_d   = '0;
                  phase_d = PH_DEAD;
                  dead_d  = '0;
                end else begin
                  row_d = row_q + ROW_AW'(1);
                end
              end else begin
                bit_d = bit_q + plsbd_pkg::BIT_W'(1);
              end
            end
          end else if (phase_q == PH_DEAD) begin
            if (wrap) begin
              if (dead_q < cfg_i.dead_periods) begin
                dead_d = dead_q + plsbd_pkg::BYTE_W'(1);
              end else begin
                dead_d  = '0;
                phase_d = PH_IDLE;
                done_d  = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= plsbd_pkg::preload(plsbd_pkg::PERIOD_TICKS_RST);
      dead_q  <= '0;
      bit_q   <= '0;
      row_q   <= '0;
      pin_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      dead_q  <= dead_d;
      bit_q   <= bit_d;
      row_q   <= row_d;
      pin_q   <= pin_d;
      done_q  <= done_d;
    end
  end

  // prefetch the row the next item will use
  assign rd_row_o = row_d;
  assign pins_o   = pin_q;
  assign busy_o   = (phase_q != PH_IDLE);
  assign done_o   = done_q;

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((phase_q != PH_IDLE) && done_q))
    else $error("busy and done both set");

  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_q <= plsbd_pkg::LAST_BIT)
    else $error("bit position out of range");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (op_i == plsbd_pkg::OP_START))
    |=> ((phase_q == PH_SEND) && (bit_q == '0) && (row_q == '0) && !done_q))
    else $error("start request did not restart the frame");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (op_i == plsbd_pkg::OP_TICK) && (phase_q == PH_IDLE))
    |=> ($stable(pin_q) && (phase_q == PH_IDLE)))
    else $error("tick changed state while idle");

  a_done_from_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> ($past(phase_q) == PH_DEAD))
    else $error("done raised outside dead time");

endmodule

`default_nettype wire

// File: design/parallel_led_strip_bitslice_driver_unit.sv
// parallel_led_strip_bitslice_driver_unit: top level with request register, config registers
// and result handshake; instantiates plsbd_store and plsbd_ctrl, uses plsbd_pkg
`default_nettype none

// Drives LANES one-wire LED strips in parallel from a bit-sliced frame store. A set-pixel
// request writes one LED of one lane, a start request begins a frame, and each tick request
// advances the bit-period timer; every request gives one result with the pin levels, busy
// and done after that request. One request is taken every clock cycle while the result side
// does not stall; a request passes through the request register, then through the sequencer
// into the result register. The store row for the current LED is prefetched from the
// sequencer's next row, so ticks run at full rate. After reset the store is cleared one
// row per cycle while no request is accepted; configuration writes are taken at all times.
module parallel_led_strip_bitslice_driver_unit #(
  parameter int LANES         = plsbd_pkg::LANES_DEF,
  parameter int LEDS_PER_LANE = plsbd_pkg::LEDS_PER_LANE_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [plsbd_pkg::OP_W-1:0]           operation_i,
  input  wire logic [plsbd_pkg::LANE_W-1:0]         lane_i,
  input  wire logic [plsbd_pkg::LED_W-1:0]          led_index_i,
  input  wire logic [plsbd_pkg::BYTE_W-1:0]         red_i,
  input  wire logic [plsbd_pkg::BYTE_W-1:0]         green_i,
  input  wire logic [plsbd_pkg::BYTE_W-1:0]         blue_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic      [LANES-1:0]                     pins_o,
  output logic                                      busy_res_o,
  output logic                                      frame_done_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [plsbd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [plsbd_pkg::BYTE_W-1:0]         cfg_data_i
);

  localparam int ROW_AW  = (LEDS_PER_LANE > 1) ? $clog2(LEDS_PER_LANE) : 1;
  localparam int LANE_AW = (LANES > 1) ? $clog2(LANES) : 1;

  logic                              req_vld_q, req_vld_d;
  plsbd_pkg::op_e                    op_q;
  logic [plsbd_pkg::LANE_W-1:0]      lane_q;
  logic [plsbd_pkg::LED_W-1:0]       led_q;
  logic [plsbd_pkg::COLOR_W-1:0]     color_q;
  logic                              out_vld_q, out_vld_d;
  plsbd_pkg::cfg_t                   cfg_q, cfg_d;

  logic                              accept;
  logic                              step;
  logic                              clr_busy;
  logic                              wr_en;
  logic [ROW_AW-1:0]                 wr_row;
  logic [LANE_AW-1:0]                wr_lane;
  logic [plsbd_pkg::COLOR_W-1:0]     wr_data;
  logic [ROW_AW-1:0]                 rd_row;
  logic [LANES-1:0][plsbd_pkg::COLOR_W-1:0] rd_data;

  // the held request moves on whenever the result slot is free or being taken
  assign step       = req_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = clr_busy || (req_vld_q && !step);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    req_vld_d = req_vld_q;
    if (accept) begin
      req_vld_d = 1'b1;
    end else if (step) begin
      req_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (step) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (plsbd_pkg::cfg_idx_e'(cfg_index_i))
        plsbd_pkg::CFG_PERIOD_TICKS: cfg_d.period_ticks = cfg_data_i;
        plsbd_pkg::CFG_DATA_TICK:    cfg_d.data_tick    = cfg_data_i;
        plsbd_pkg::CFG_LOW_TICK:     cfg_d.low_tick     = cfg_data_i;
        plsbd_pkg::CFG_DEAD_PERIODS: cfg_d.dead_periods = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q          <= 1'b0;
      out_vld_q          <= 1'b0;
      cfg_q.period_ticks <= plsbd_pkg::PERIOD_TICKS_RST;
      cfg_q.data_tick    <= plsbd_pkg::DATA_TICK_RST;
      cfg_q.low_tick     <= plsbd_pkg::LOW_TICK_RST;
      cfg_q.dead_periods <= plsbd_pkg::DEAD_PERIODS_RST;
    end else begin
      req_vld_q <= req_vld_d;
      out_vld_q <= out_vld_d;
      cfg_q     <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= plsbd_pkg::op_e'(operation_i);
      lane_q  <= lane_i;
      led_q   <= led_index_i;
      color_q <= {green_i, red_i, blue_i};
    end
  end

  plsbd_store #(
    .LANES (LANES),
    .ROWS  (LEDS_PER_LANE)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_row_i   (wr_row),
    .wr_lane_i  (wr_lane),
    .wr_data_i  (wr_data),
    .rd_row_i   (rd_row),
    .rd_data_o  (rd_data),
    .clr_busy_o (clr_busy)
  );

  plsbd_ctrl #(
    .LANES (LANES),
    .ROWS  (LEDS_PER_LANE)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .op_i      (op_q),
    .lane_i    (lane_q),
    .led_i     (led_q),
    .color_i   (color_q),
    .cfg_i     (cfg_q),
    .wr_en_o   (wr_en),
    .wr_row_o  (wr_row),
    .wr_lane_o (wr_lane),
    .wr_data_o (wr_data),
    .rd_row_o  (rd_row),
    .rd_data_i (rd_data),
    .pins_o    (pins_o),
    .busy_o    (busy_res_o),
    .done_o    (frame_done_o)
  );

  assign out_valid_o = out_vld_q;
  assign cfg_ready_o = 1'b1;

endmodule

`default_nettype wire
